// ===== src/urs_pkg.sv =====
`default_nettype none
package urs_pkg;

  // Urn geometry
  localparam int CATEGORIES = 10;
  localparam int CAT_W      = 4;
  localparam int CNT_W      = 10;
  localparam int MAX_COUNT  = 1023;
  localparam int TOT_W      = 14;
  localparam int MAX_TOTAL  = CATEGORIES * MAX_COUNT;

  // Remainder unit: two dividend bits per step
  localparam int WORD_W     = 64;
  localparam int MOD_STEPS  = WORD_W / 2;
  localparam int STEP_W     = 5;

  // SplitMix64 constants
  localparam logic [63:0] GOLDEN_STEP = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  // Input command codes
  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_DRAW   = 2'd1,
    CMD_RESEED = 2'd2,
    CMD_RSVD   = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FLOOR, S_GEN, S_M1, S_X1, S_M2, S_X2, S_CHK, S_SEL, S_WALK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_RESEED, OP_EMPTY, OP_PASS, OP_FLOOR_INIT, OP_MOD,
    OP_GEN, OP_MUL, OP_XS, OP_SEL_INIT, OP_WALK, OP_OUT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic             csel;   // 0: first mix constant / shift 27, 1: second / shift 31
    logic [1:0]       mph;    // partial-product phase
    logic [CAT_W-1:0] idx;    // category index
  } dp_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic word_ok;
    logic hit;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/urs_ctrl.sv =====
`default_nettype none
module urs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_tvalid,
  input  wire urs_pkg::cmd_t             in_command,
  input  wire logic [urs_pkg::CAT_W-1:0] in_category,
  input  wire logic                      out_tready,
  input  wire urs_pkg::dp_stat_t         stat,
  output logic                           in_tready,
  output logic                           out_tvalid,
  output urs_pkg::dp_cmd_t               cmd
);
  import urs_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    cmd           = '{op: OP_NONE, csel: 1'b0, mph: 2'd0, idx: '0};
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_DONE;
          unique case (in_command)
            CMD_LOAD: begin
              cmd.op  = OP_LOAD;
              cmd.idx = in_category;
            end
            CMD_DRAW: begin
              if (stat.total_zero) begin
                cmd.op = OP_EMPTY;
              end else begin
                cmd.op    = OP_FLOOR_INIT;
                step_nxt  = '0;
                state_nxt = S_FLOOR;
              end
            end
            CMD_RESEED: cmd.op = OP_RESEED;
            default:    cmd.op = OP_PASS;
          endcase
        end
      end
      S_FLOOR, S_SEL: begin
        cmd.op = OP_MOD;
        if (step_r == STEP_W'(MOD_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = (state_r == S_FLOOR) ? S_GEN : S_WALK;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_GEN: begin
        cmd.op    = OP_GEN;
        step_nxt  = '0;
        state_nxt = S_M1;
      end
      S_M1, S_M2: begin
        cmd.op   = OP_MUL;
        cmd.csel = (state_r == S_M2);
        cmd.mph  = step_r[1:0];
        if (step_r == STEP_W'(2)) begin
          step_nxt  = '0;
          state_nxt = (state_r == S_M1) ? S_X1 : S_X2;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_X1: begin
        cmd.op    = OP_XS;
        state_nxt = S_M2;
      end
      S_X2: begin
        cmd.op    = OP_XS;
        cmd.csel  = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        // reject words below the bias floor
        if (stat.word_ok) begin
          cmd.op    = OP_SEL_INIT;
          step_nxt  = '0;
          state_nxt = S_SEL;
        end else begin
          state_nxt = S_GEN;
        end
      end
      S_WALK: begin
        cmd.op  = OP_WALK;
        cmd.idx = step_r[CAT_W-1:0];
        if (stat.hit) begin
          state_nxt = S_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

endmodule
`default_nettype wire

// ===== src/urs_dp.sv =====
`default_nettype none
module urs_dp (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire urs_pkg::dp_cmd_t          cmd,
  input  wire logic [urs_pkg::CNT_W-1:0] in_count_value,
  input  wire logic [63:0]               seed,
  output urs_pkg::dp_stat_t              stat,
  output logic [urs_pkg::CAT_W-1:0]      out_drawn_category,
  output logic                           out_urn_empty,
  output logic [urs_pkg::TOT_W-1:0]      out_remaining_total
);
  import urs_pkg::*;

  logic [63:0]      gen_r;
  logic [63:0]      z_r;
  logic [63:0]      acc_r;
  logic [63:0]      dvd_r;
  logic [TOT_W-1:0] rem_r;
  logic [TOT_W-1:0] run_r;
  logic [TOT_W-1:0] total_r;
  logic [CNT_W-1:0] cnt_r [CATEGORIES];
  logic [CAT_W-1:0] res_drawn_r, out_drawn_r;
  logic             res_empty_r, out_empty_r;
  logic [TOT_W-1:0] out_total_r;

  logic [CNT_W-1:0] cnt_rd;
  logic [CNT_W-1:0] load_val;
  logic [TOT_W-1:0] run_nxt;
  logic [TOT_W:0]   r1, r2;
  logic [TOT_W:0]   tot_ext;
  logic [TOT_W-1:0] rem_nxt;
  logic [63:0]      mconst;
  logic [31:0]      ma, mb;
  logic [63:0]      prod;
  logic [63:0]      gen_sum;
  logic             cat_ok;

  assign cnt_rd   = cnt_r[cmd.idx];
  assign load_val = (in_count_value > CNT_W'(MAX_COUNT)) ? CNT_W'(MAX_COUNT) : in_count_value;
  assign cat_ok   = (cmd.idx < CAT_W'(CATEGORIES));
  assign run_nxt  = run_r + TOT_W'(cnt_rd);

  // Remainder step: two restoring subtract stages
  assign tot_ext = {1'b0, total_r};
  always_comb begin
    r1 = {rem_r, dvd_r[63]};
    if (r1 >= tot_ext) r1 = r1 - tot_ext;
    r2 = {r1[TOT_W-1:0], dvd_r[62]};
    if (r2 >= tot_ext) r2 = r2 - tot_ext;
    rem_nxt = r2[TOT_W-1:0];
  end

  // Shared 32x32 multiplier for the 64-bit low product
  assign mconst = cmd.csel ? MIX_MUL_B : MIX_MUL_A;
  assign ma     = (cmd.mph == 2'd2) ? z_r[63:32] : z_r[31:0];
  assign mb     = (cmd.mph == 2'd1) ? mconst[63:32] : mconst[31:0];
  assign prod   = ma * mb;
  assign gen_sum = gen_r + GOLDEN_STEP;

  // Status
  assign stat.total_zero = (total_r == '0);
  assign stat.word_ok    = (z_r >= {{(64-TOT_W){1'b0}}, rem_r});
  assign stat.hit        = (cmd.op == OP_WALK) && (rem_r < run_nxt);

  // Urn state and generator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r   <= '0;
      total_r <= '0;
      for (int i = 0; i < CATEGORIES; i++) cnt_r[i] <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          if (cat_ok) begin
            cnt_r[cmd.idx] <= load_val;
            total_r        <= total_r - TOT_W'(cnt_rd) + TOT_W'(load_val);
          end
        end
        OP_RESEED: gen_r <= seed;
        OP_GEN:    gen_r <= gen_sum;
        OP_WALK: begin
          if (stat.hit) begin
            cnt_r[cmd.idx] <= cnt_rd - 1'b1;
            total_r        <= total_r - 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD, OP_RESEED, OP_EMPTY, OP_PASS, OP_FLOOR_INIT: begin
        res_drawn_r <= '0;
        res_empty_r <= (cmd.op == OP_EMPTY);
        // bias floor is 2^64 mod total
        dvd_r       <= 64'd0 - {{(64-TOT_W){1'b0}}, total_r};
        rem_r       <= '0;
      end
      OP_MOD: begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[61:0], 2'b00};
      end
      OP_GEN: z_r <= gen_sum ^ (gen_sum >> 30);
      OP_MUL: begin
        if (cmd.mph == 2'd0) acc_r <= prod;
        else                 acc_r <= acc_r + {prod[31:0], 32'd0};
      end
      OP_XS: z_r <= cmd.csel ? (acc_r ^ (acc_r >> 31)) : (acc_r ^ (acc_r >> 27));
      OP_SEL_INIT: begin
        dvd_r <= z_r;
        rem_r <= '0;
        run_r <= '0;
      end
      OP_WALK: begin
        run_r <= run_nxt;
        if (stat.hit) res_drawn_r <= cmd.idx;
      end
      OP_OUT: begin
        out_drawn_r <= res_drawn_r;
        out_empty_r <= res_empty_r;
        out_total_r <= total_r;
      end
      default: ;
    endcase
  end

  assign out_drawn_category  = out_drawn_r;
  assign out_urn_empty       = out_empty_r;
  assign out_remaining_total = out_total_r;

endmodule
`default_nettype wire

// ===== src/urn_sampler_splitmix64.sv =====
// Urn sampler: draws categories without replacement from up to ten stored counts using a
// SplitMix64 generator with modulo rejection. One word in, one word out. Load, reseed and
// unknown commands and an empty draw go from idle straight to the output state. A draw finds
// the bias floor and, after words below it are rejected, reduces the accepted word, both in
// a 2-bit-per-cycle remainder unit; each generator word is mixed on one shared 32x32
// multiplier, and a cumulative walk over the categories picks the drawn one. A finished word
// waits in the output register; the next input word is taken once the controller is back in idle.
`default_nettype none
module urn_sampler_splitmix64 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // slave side
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // command[1:0], category[5:2], count_value[15:6]
  // master side
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // drawn_category[3:0], urn_empty[4],
                                       // remaining_total[18:5], zero[23:19]
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [63:0] cfg_pwdata,
  output logic [63:0]      cfg_prdata,
  output logic             cfg_pready
);
  import urs_pkg::*;

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [63:0]      seed_r;
  logic             seed_sel;
  logic [CAT_W-1:0] drawn;
  logic             empty;
  logic [TOT_W-1:0] total;

  // Seed register at byte addresses 0 to 7 (cfg_paddr[3] low)
  assign seed_sel   = (cfg_paddr[3] == 1'b0);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = seed_sel ? seed_r : 64'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && seed_sel) begin
      seed_r <= cfg_pwdata;
    end
  end

  urs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_command  (cmd_t'(in_tdata[1:0])),
    .in_category (in_tdata[5:2]),
    .out_tready  (out_tready),
    .stat        (stat),
    .in_tready   (in_tready),
    .out_tvalid  (out_tvalid),
    .cmd         (cmd)
  );

  urs_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .in_count_value      (in_tdata[15:6]),
    .seed                (seed_r),
    .stat                (stat),
    .out_drawn_category  (drawn),
    .out_urn_empty       (empty),
    .out_remaining_total (total)
  );

  assign out_tdata = {5'd0, total, empty, drawn};

endmodule
`default_nettype wire

// ===== src/urs_check.sv =====
`default_nettype none
module urs_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        cfg_pready
);
  import urs_pkg::*;

  // A held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  // One word in flight: intake closes right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word accepted while busy");

  // An empty draw names no category
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4] |-> out_tdata[3:0] == 4'd0)
    else $error("empty draw carries a category");

  // Total stays within urn capacity
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:5] <= TOT_W'(MAX_TOTAL) && out_tdata[23:19] == 5'd0)
    else $error("remaining total out of range");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("config port not ready");

endmodule

bind urn_sampler_splitmix64 urs_check u_urs_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

// ===== dv/urn_sampler_splitmix64_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
module urn_sampler_splitmix64_tb;
  import urs_pkg::*;

  // Expected-word record
  typedef struct {
    logic [CAT_W-1:0] drawn;
    logic             empty;
    logic [TOT_W-1:0] total;
  } draw_word_t;

  // Urn predictor and queue of expected words
  class urn_scoreboard;
    logic [63:0]      seed_reg;
    logic [63:0]      gen_state;
    logic [CNT_W-1:0] counts[CATEGORIES];
    logic [TOT_W-1:0] total;
    draw_word_t       pending[$];
    int               errors;
    int               draws;
    int               empties;

    function void clear();
      seed_reg = '0;
      gen_state = '0;
      total = '0;
      errors = 0;
      draws = 0;
      empties = 0;
      for (int i = 0; i < CATEGORIES; i++) counts[i] = '0;
    endfunction

    function logic [63:0] next_word();
      logic [63:0] z;
      gen_state = gen_state + GOLDEN_STEP;
      z = gen_state;
      z = (z ^ (z >> 30)) * MIX_MUL_A;
      z = (z ^ (z >> 27)) * MIX_MUL_B;
      return z ^ (z >> 31);
    endfunction

    // Predict the word for one accepted command
    function void note_command(cmd_t cmd, logic [3:0] cat, logic [CNT_W-1:0] val);
      draw_word_t  exp_w;
      logic [63:0] lim, floor_v, w, sel, run;
      exp_w.drawn = '0;
      exp_w.empty = 1'b0;
      case (cmd)
        CMD_LOAD: begin
          if (cat < CATEGORIES) begin
            total = total - counts[cat] + val;
            counts[cat] = val;
          end
        end
        CMD_DRAW: begin
          if (total == 0) begin
            exp_w.empty = 1'b1;
            empties++;
          end else begin
            lim = 64'(total);
            floor_v = (64'd0 - lim) % lim;
            do w = next_word(); while (w < floor_v);
            sel = w % lim;
            run = '0;
            for (int i = 0; i < CATEGORIES; i++) begin
              run = run + counts[i];
              if (sel < run) begin
                counts[i]--;
                total--;
                exp_w.drawn = CAT_W'(i);
                break;
              end
            end
            draws++;
          end
        end
        CMD_RESEED: gen_state = seed_reg;
        default: ;
      endcase
      exp_w.total = total;
      pending.push_back(exp_w);
    endfunction

    function void check_word(logic [23:0] d);
      draw_word_t e;
      if (pending.size() == 0) begin
        $error("unexpected output word %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[3:0] !== e.drawn) begin
        $error("drawn_category expected %0d actual %0d", e.drawn, d[3:0]);
        errors++;
      end
      if (d[4] !== e.empty) begin
        $error("urn_empty expected %0d actual %0d", e.empty, d[4]);
        errors++;
      end
      if (d[18:5] !== e.total) begin
        $error("remaining_total expected %0d actual %0d", e.total, d[18:5]);
        errors++;
      end
      if (d[23:19] !== 5'd0) begin
        $error("pad expected 0 actual %0d", d[23:19]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // command[1:0], category[5:2], count_value[15:6]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // drawn_category[3:0], urn_empty[4], remaining_total[18:5]
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  urn_scoreboard urn_sb = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int words_sent = 0;

  urn_sampler_splitmix64 dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check on rising edge, randomize ready on falling edge
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) urn_sb.check_word(out_tdata);
  end
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Valid stays up after an accept until the next falling edge that drives the bus
  task automatic send_command(cmd_t cmd, logic [3:0] cat, logic [CNT_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {val, cat, cmd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    urn_sb.note_command(cmd, cat, val);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic drain_words();
    in_tvalid <= 1'b0;
    while (urn_sb.pending.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Seed write through the register port; only while idle
  task automatic write_seed(logic [63:0] value);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= '0;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    urn_sb.seed_reg = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic random_command();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      send_command(CMD_DRAW, 4'($urandom), 10'($urandom));
    else if (r < 88)
      send_command(CMD_LOAD, 4'($urandom_range(11)),
                   ($urandom_range(3) == 0) ? 10'($urandom) : 10'($urandom_range(12)));
    else if (r < 95)
      send_command(CMD_RESEED, 4'($urandom), 10'($urandom));
    else
      send_command(CMD_RSVD, 4'($urandom), 10'($urandom));
  endtask

  initial begin
    urn_sb.clear();
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty draw, extremes, reserved command, out-of-range category
    send_command(CMD_DRAW, 4'd0, 10'd0);
    send_command(CMD_LOAD, 4'd0, 10'd1023);
    send_command(CMD_LOAD, 4'd9, 10'd1);
    send_command(CMD_LOAD, 4'd10, 10'd5);
    send_command(CMD_LOAD, 4'd15, 10'd1023);
    send_command(CMD_RSVD, 4'd15, 10'd1023);
    send_command(CMD_DRAW, 4'd15, 10'd1023);
    send_command(CMD_DRAW, 4'd0, 10'd0);
    drain_words();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    send_command(CMD_RESEED, 4'd0, 10'd0);
    for (int i = 0; i < CATEGORIES; i++) send_command(CMD_LOAD, 4'(i), 10'd1023);
    send_command(CMD_DRAW, 4'd0, 10'd0);
    send_command(CMD_DRAW, 4'd0, 10'd0);
    for (int i = 0; i < CATEGORIES; i++) send_command(CMD_LOAD, 4'(i), 10'd0);
    send_command(CMD_LOAD, 4'd3, 10'd1);
    send_command(CMD_DRAW, 4'd0, 10'd0);
    send_command(CMD_DRAW, 4'd0, 10'd0);

    // Random phases under three idle patterns, new seed per phase
    for (int ph = 0; ph < 3; ph++) begin
      drain_words();
      write_seed(ph == 0 ? 64'd0 : {$urandom, $urandom});
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 11 : 0;
      send_command(CMD_RESEED, 4'd0, 10'd0);
      for (int n = 0; n < 410; n++) begin
        if (n == 200) begin
          // hold off until the urn has answered everything
          in_tvalid <= 1'b0;
          while (urn_sb.pending.size() != 0) @(negedge clk);
        end
        random_command();
      end
    end

    drain_words();
    repeat (200) @(negedge clk);
    $display("Sent %0d words: %0d draws, %0d empty draws, three seed phases.",
             words_sent, urn_sb.draws, urn_sb.empties);
    if (urn_sb.errors == 0 && urn_sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
